// File: src/linear_interp_resampler_unit_assert.svh
// Assertion macros used by the resampler back end (lirs_back).
`ifndef LINEAR_INTERP_RESAMPLER_UNIT_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LIRS_ASSERT_IMPL(label, clk_i, rst_ni, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define LIRS_ASSERT_NEXT(label, clk_i, rst_ni, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/lirs_pkg.sv
// Shared widths, register codes, command type and division step of the resampler.
package lirs_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int RATIO_W    = 12;
	localparam int RES_W      = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int MAX_RUN    = 64;
	localparam int CNT_W      = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
	localparam int RUN_SUM_W  = RATIO_W + $clog2(MAX_RUN + 1) + 1;
	localparam int PROD_W     = SAMPLE_W + RATIO_W + 1;
	localparam int ACC_W      = PROD_W + 1;
	localparam int MAG_W      = SAMPLE_W - 1 + RATIO_W;
	localparam int QUOT_LIMIT = 2 ** (SAMPLE_W - 1);
	localparam int FSTEP_W    = $clog2(RATIO_W);
	localparam int BSTEP_W    = $clog2(MAG_W);
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [RATIO_W-1:0] UP_RESET   = RATIO_W'(147);
	localparam logic [RATIO_W-1:0] DOWN_RESET = RATIO_W'(160);

	localparam logic [CFG_IDX_W-1:0] REG_UP   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DOWN = CFG_IDX_W'(1);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] prev;
		logic signed [SAMPLE_W-1:0] cur;
		logic [RATIO_W-1:0]         phase;
		logic [RATIO_W-1:0]         up;
		logic [RATIO_W-1:0]         down;
		logic                       dropped;
	} lirs_cmd_t;

	// One restoring step: returns {quotient bit, next remainder}.
	function automatic logic [RATIO_W:0] div_step(input logic [RATIO_W-1:0] rem,
		input logic din, input logic [RATIO_W-1:0] divisor);
		logic [RATIO_W:0] shifted;
		logic [RATIO_W:0] diff;
		shifted = {rem, din};
		diff    = shifted - {1'b0, divisor};
		if (shifted >= {1'b0, divisor}) begin
			div_step = {1'b1, diff[RATIO_W-1:0]};
		end else begin
			div_step = {1'b0, shifted[RATIO_W-1:0]};
		end
	endfunction

endpackage

// File: src/linear_interp_resampler_unit.sv
// Linear-interpolation rational resampler, top level.
//
// Samples enter on the item channel (item_valid/item_ready, sample_in,
// block_last); interpolated samples leave on the result channel
// (result_valid/result_ready, sample_out, run_last, run_dropped).
// up_factor (index 0) and down_factor (index 1) are written on the cfg
// channel, which is always ready; write them only while the block is idle.
// The front end takes one sample, then, if it makes output, runs a serial
// remainder by down_factor to advance the phase and issues a command into
// a two-entry queue, taking no new sample until the command is queued.
// A sample that makes no output only updates the phase and stored sample.
// For each output the back end forms the weighted sum (B_MUL, B_ADD), runs
// the serial division by up_factor (B_DIV) and loads the result register
// (B_EMIT); it takes a new command only after the last output of its run.
// When the receiver stalls, the result register holds and the back end and
// then the queue fill, after which item_ready drops.
// Reset clears the phase, the stored sample and the queue, and loads
// the 147/160 ratio.
module linear_interp_resampler_unit import lirs_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [RATIO_W-1:0]          cfg_data,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic signed [SAMPLE_W-1:0]  sample_in,
	input  logic                        block_last,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic signed [SAMPLE_W-1:0]  sample_out,
	output logic                        run_last,
	output logic                        run_dropped
);

	logic      push_valid;
	logic      push_ready;
	lirs_cmd_t push_data;
	logic      pop_valid;
	logic      pop_ready;
	lirs_cmd_t pop_data;

	lirs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sample_in  (sample_in),
		.block_last (block_last),
		.cmd_valid  (push_valid),
		.cmd_ready  (push_ready),
		.cmd_data   (push_data)
	);

	lirs_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	lirs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (pop_valid),
		.cmd_ready    (pop_ready),
		.cmd_data     (pop_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sample_out   (sample_out),
		.run_last     (run_last),
		.run_dropped  (run_dropped)
	);

endmodule

// File: src/lirs_front.sv
// Front end: config registers, item transfer, phase bookkeeping and command issue.
module lirs_front import lirs_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [RATIO_W-1:0]          cfg_data,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic signed [SAMPLE_W-1:0]  sample_in,
	input  logic                        block_last,
	output logic                        cmd_valid,
	input  logic                        cmd_ready,
	output lirs_cmd_t                   cmd_data
);

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;

	front_state_t               state_q;
	logic [RATIO_W-1:0]         up_q;
	logic [RATIO_W-1:0]         down_q;
	logic signed [SAMPLE_W-1:0] prev_q;
	logic [RES_W-1:0]           res_q;
	logic                       started_q;
	lirs_cmd_t                  cmd_q;
	logic                       last_q;
	logic [RATIO_W-1:0]         div_q;
	logic [RATIO_W-1:0]         rem_q;
	logic [FSTEP_W-1:0]         step_q;

	logic [RATIO_W-1:0]         up_eff;
	logic [RATIO_W-1:0]         down_eff;
	logic [RES_W-1:0]           r0;
	logic signed [SAMPLE_W-1:0] prev0;
	logic                       skip;
	logic [RUN_SUM_W-1:0]       run_sum;
	logic                       drop;
	logic [RATIO_W:0]           step_res;

	always_comb begin
		up_eff   = (up_q == '0) ? RATIO_W'(1) : up_q;
		down_eff = (down_q == '0) ? RATIO_W'(1) : down_q;
		r0       = started_q ? res_q : {1'b0, up_eff};
		prev0    = started_q ? prev_q : '0;
		skip     = r0 > {1'b0, up_eff};
		run_sum  = RUN_SUM_W'(r0) + RUN_SUM_W'(down_eff) * RUN_SUM_W'(MAX_RUN);
		drop     = run_sum <= RUN_SUM_W'(up_eff);
		step_res = div_step(rem_q, div_q[RATIO_W-1], cmd_q.down);
	end

	assign cfg_ready  = 1'b1;
	assign item_ready = (state_q == F_IDLE);
	assign cmd_valid  = (state_q == F_PUSH);
	assign cmd_data   = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			up_q      <= UP_RESET;
			down_q    <= DOWN_RESET;
			prev_q    <= '0;
			res_q     <= '0;
			started_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_UP:   up_q   <= cfg_data;
					REG_DOWN: down_q <= cfg_data;
					default:  ;
				endcase
			end
			unique case (state_q)
				F_IDLE: begin
					if (item_valid) begin
						if (skip) begin
							// no output position in this interval
							if (block_last) begin
								prev_q    <= '0;
								res_q     <= '0;
								started_q <= 1'b0;
							end else begin
								prev_q    <= sample_in;
								res_q     <= r0 - {1'b0, up_eff};
								started_q <= 1'b1;
							end
						end else begin
							cmd_q.prev    <= prev0;
							cmd_q.cur     <= sample_in;
							cmd_q.phase   <= r0[RATIO_W-1:0];
							cmd_q.up      <= up_eff;
							cmd_q.down    <= down_eff;
							cmd_q.dropped <= drop;
							last_q        <= block_last;
							div_q         <= up_eff - r0[RATIO_W-1:0];
							rem_q         <= '0;
							step_q        <= '0;
							state_q       <= F_DIV;
						end
					end
				end
				F_DIV: begin
					rem_q  <= step_res[RATIO_W-1:0];
					div_q  <= {div_q[RATIO_W-2:0], 1'b0};
					step_q <= step_q + 1'b1;
					if (step_q == FSTEP_W'(RATIO_W - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (cmd_ready) begin
						if (last_q) begin
							prev_q    <= '0;
							res_q     <= '0;
							started_q <= 1'b0;
						end else begin
							prev_q    <= cmd_q.cur;
							res_q     <= RES_W'(cmd_q.down - rem_q);
							started_q <= 1'b1;
						end
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// File: src/lirs_cmd_fifo.sv
// Short command queue between the front end and the interpolation back end.
module lirs_cmd_fifo import lirs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  lirs_cmd_t push_data,
	output logic      pop_valid,
	input  logic      pop_ready,
	output lirs_cmd_t pop_data
);

	lirs_cmd_t            mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = (count_q != FIFO_CW'(FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/lirs_back.sv
// Back end: per-output weighting, serial division by up and result register.
`include "linear_interp_resampler_unit_assert.svh"
module lirs_back import lirs_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  lirs_cmd_t                   cmd_data,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic signed [SAMPLE_W-1:0]  sample_out,
	output logic                        run_last,
	output logic                        run_dropped
);

	typedef enum logic [2:0] {B_IDLE, B_MUL, B_ADD, B_DIV, B_EMIT} back_state_t;

	back_state_t                state_q;
	lirs_cmd_t                  cmd_q;
	logic [RATIO_W-1:0]         p_q;
	logic [CNT_W-1:0]           cnt_q;
	logic signed [PROD_W-1:0]   prod_a_q;
	logic signed [PROD_W-1:0]   prod_b_q;
	logic                       neg_q;
	logic [MAG_W-1:0]           quot_q;
	logic [RATIO_W-1:0]         rem_q;
	logic [BSTEP_W-1:0]         step_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       last_q;
	logic                       drop_q;

	logic signed [ACC_W-1:0]    acc;
	logic signed [ACC_W-1:0]    acc_abs;
	logic [RATIO_W:0]           step_res;
	logic [MAG_W-1:0]           quot_signed;
	logic [RATIO_W:0]           p_next;
	logic                       is_last;
	logic                       slot_free;

	always_comb begin
		acc         = prod_a_q + prod_b_q;
		acc_abs     = acc[ACC_W-1] ? -acc : acc;
		step_res    = div_step(rem_q, quot_q[MAG_W-1], cmd_q.up);
		quot_signed = neg_q ? -quot_q : quot_q;
		p_next      = {1'b0, p_q} + {1'b0, cmd_q.down};
		is_last     = cmd_q.dropped ? (cnt_q == CNT_W'(MAX_RUN - 1))
		                            : (p_next > {1'b0, cmd_q.up});
		slot_free   = !out_valid_q || result_ready;
	end

	assign cmd_ready    = (state_q == B_IDLE);
	assign result_valid = out_valid_q;
	assign sample_out   = sample_q;
	assign run_last     = last_q;
	assign run_dropped  = drop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == B_EMIT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd_data;
						p_q     <= cmd_data.phase;
						cnt_q   <= '0;
						state_q <= B_MUL;
					end
				end
				B_MUL: begin
					prod_a_q <= cmd_q.prev * $signed({1'b0, cmd_q.up - p_q});
					prod_b_q <= cmd_q.cur * $signed({1'b0, p_q});
					state_q  <= B_ADD;
				end
				B_ADD: begin
					neg_q   <= acc[ACC_W-1];
					quot_q  <= acc_abs[MAG_W-1:0];
					rem_q   <= '0;
					step_q  <= '0;
					state_q <= B_DIV;
				end
				B_DIV: begin
					rem_q  <= step_res[RATIO_W-1:0];
					quot_q <= {quot_q[MAG_W-2:0], step_res[RATIO_W]};
					step_q <= step_q + 1'b1;
					if (step_q == BSTEP_W'(MAG_W - 1)) begin
						state_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (slot_free) begin
						sample_q    <= quot_signed[SAMPLE_W-1:0];
						last_q      <= is_last;
						drop_q      <= cmd_q.dropped;
						if (is_last) begin
							state_q <= B_IDLE;
						end else begin
							p_q     <= p_next[RATIO_W-1:0];
							cnt_q   <= cnt_q + 1'b1;
							state_q <= B_MUL;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	`LIRS_ASSERT_IMPL(a_quot_range, clk, arst_n, state_q == B_EMIT, quot_q <= MAG_W'(QUOT_LIMIT), "quotient exceeds sample range")
	`LIRS_ASSERT_IMPL(a_phase_range, clk, arst_n, state_q != B_IDLE, p_q <= cmd_q.up, "phase beyond current sample")
	`LIRS_ASSERT_IMPL(a_run_bound, clk, arst_n, state_q != B_IDLE, cnt_q <= CNT_W'(MAX_RUN - 1), "run longer than limit")
	`LIRS_ASSERT_NEXT(a_emit_loads, clk, arst_n, state_q == B_EMIT && slot_free, out_valid_q, "result not registered")

endmodule
